>>> hw/rtl/mcd_pkg.sv
// shared types and constants for the midi channel decoder with rpn/nrpn assembly
package mcd_pkg;

    // status byte upper nibbles
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_POLY_PRESS = 4'hA;
    localparam logic [3:0] KIND_CONTROL    = 4'hB;
    localparam logic [3:0] KIND_PROGRAM    = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
    localparam logic [3:0] KIND_PITCH_BEND = 4'hE;

    // event codes
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_NOTE_OFF   = 4'd1;
    localparam logic [3:0] EV_NOTE_ON    = 4'd2;
    localparam logic [3:0] EV_NOTE_ON_V0 = 4'd3;
    localparam logic [3:0] EV_POLY_PRESS = 4'd4;
    localparam logic [3:0] EV_CONTROL    = 4'd5;
    localparam logic [3:0] EV_PROGRAM    = 4'd6;
    localparam logic [3:0] EV_CHAN_PRESS = 4'd7;
    localparam logic [3:0] EV_PITCH_BEND = 4'd8;

    // controller numbers used by the parameter assembler
    localparam logic [6:0] CC_RPN_MSB   = 7'd101;
    localparam logic [6:0] CC_NRPN_MSB  = 7'd99;
    localparam logic [6:0] CC_RPN_LSB   = 7'd100;
    localparam logic [6:0] CC_NRPN_LSB  = 7'd98;
    localparam logic [6:0] CC_ENTRY_MSB = 7'd6;
    localparam logic [6:0] CC_ENTRY_LSB = 7'd38;
    localparam logic [6:0] NULL_BYTE    = 7'd127;

    // assembler steps
    localparam logic [1:0] STEP_IDLE     = 2'd0;
    localparam logic [1:0] STEP_NUM_MSB  = 2'd1;
    localparam logic [1:0] STEP_NUM_LSB  = 2'd2;
    localparam logic [1:0] STEP_ENTRY    = 2'd3;

    localparam int NUM_NOTES = 128;
    localparam int COUNT_W   = 8;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RPN  = 2'd1,
        MODE_NRPN = 2'd2
    } t_asm_mode;

    typedef struct packed {
        t_asm_mode  mode;
        logic [1:0] step;
        logic [6:0] number_high;
        logic [6:0] number_low;
        logic [6:0] entry_high;
    } t_asm_state;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [6:0]  index;
        logic [13:0] value;
        logic        param_done;
        logic        param_is_nrpn;
        logic [13:0] param_number;
        logic [13:0] param_value;
    } t_decode_res;

    typedef struct packed {
        logic note_set;
        logic note_clr;
    } t_note_op;

endpackage

>>> hw/rtl/mcd_decode.sv
// message decode and rpn/nrpn assembler next-state logic
module mcd_decode
    import mcd_pkg::*;
(
    input  logic [7:0]  i_status,
    input  logic [6:0]  i_data_one,
    input  logic [6:0]  i_data_two,
    input  logic        i_held,
    input  t_asm_state  i_asm,
    output t_asm_state  o_asm,
    output t_decode_res o_res,
    output t_note_op    o_note
);

    logic [3:0]  kind;
    logic [3:0]  ev;
    logic [13:0] val;
    logic        consumed;
    t_asm_state  nxt;

    assign kind = i_status[7:4];

    always_comb begin
        nxt                 = i_asm;
        ev                  = EV_NONE;
        val                 = '0;
        consumed            = 1'b0;
        o_note              = '0;
        o_res               = '0;

        // any non-control message drops the assembler back to idle
        if (kind != KIND_CONTROL) begin
            nxt.mode = MODE_IDLE;
            nxt.step = STEP_IDLE;
        end

        case (kind)
            KIND_NOTE_OFF: begin
                ev              = EV_NOTE_OFF;
                val             = {7'd0, i_data_two};
                o_note.note_clr = i_held;
            end
            KIND_NOTE_ON: begin
                val = {7'd0, i_data_one};
                if (i_data_two != 7'd0) begin
                    ev              = EV_NOTE_ON;
                    o_note.note_set = !i_held;
                end else begin
                    ev              = EV_NOTE_ON_V0;
                    o_note.note_clr = i_held;
                end
            end
            KIND_POLY_PRESS: begin
                ev  = EV_POLY_PRESS;
                val = {7'd0, i_data_two};
            end
            KIND_CONTROL: begin
                // pending entry: finish with lsb or report msb alone
                if (i_asm.step == STEP_ENTRY) begin
                    o_res.param_done    = 1'b1;
                    o_res.param_is_nrpn = (i_asm.mode == MODE_NRPN);
                    o_res.param_number  = {i_asm.number_high, i_asm.number_low};
                    if (i_data_one == CC_ENTRY_LSB) begin
                        o_res.param_value = {i_asm.entry_high, i_data_two};
                        consumed          = 1'b1;
                    end else begin
                        o_res.param_value = {7'd0, i_asm.entry_high};
                    end
                    nxt.mode = MODE_IDLE;
                    nxt.step = STEP_IDLE;
                end
                // sequence tracking
                if (!consumed) begin
                    if (nxt.mode == MODE_IDLE) begin
                        if (i_data_one == CC_RPN_MSB || i_data_one == CC_NRPN_MSB) begin
                            nxt.mode        = (i_data_one == CC_RPN_MSB) ? MODE_RPN
                                                                         : MODE_NRPN;
                            nxt.step        = STEP_NUM_MSB;
                            nxt.number_high = i_data_two;
                            consumed        = 1'b1;
                        end
                    end else if (i_asm.step == STEP_NUM_MSB) begin
                        if ((i_asm.mode == MODE_RPN && i_data_one == CC_RPN_LSB) ||
                            (i_asm.mode == MODE_NRPN && i_data_one == CC_NRPN_LSB)) begin
                            nxt.step       = STEP_NUM_LSB;
                            nxt.number_low = i_data_two;
                            consumed       = 1'b1;
                            if (i_asm.number_high == NULL_BYTE && i_data_two == NULL_BYTE) begin
                                nxt.mode = MODE_IDLE;
                                nxt.step = STEP_IDLE;
                            end
                        end else begin
                            nxt.mode = MODE_IDLE;
                            nxt.step = STEP_IDLE;
                        end
                    end else if (i_asm.step == STEP_NUM_LSB &&
                                 i_data_one == CC_ENTRY_MSB) begin
                        nxt.entry_high = i_data_two;
                        nxt.step       = STEP_ENTRY;
                        consumed       = 1'b1;
                    end else begin
                        nxt.mode = MODE_IDLE;
                        nxt.step = STEP_IDLE;
                    end
                end
                if (!consumed) begin
                    ev  = EV_CONTROL;
                    val = {7'd0, i_data_two};
                end
            end
            KIND_PROGRAM: begin
                ev  = EV_PROGRAM;
                val = {7'd0, i_data_two};
            end
            KIND_CHAN_PRESS: begin
                ev  = EV_CHAN_PRESS;
                val = {7'd0, i_data_two};
            end
            KIND_PITCH_BEND: begin
                ev  = EV_PITCH_BEND;
                val = {i_data_two, i_data_one};
            end
            default: begin
                ev = EV_NONE;
            end
        endcase

        // event fields read as zero when there is no event
        o_res.event_res = ev;
        o_res.index     = (ev != EV_NONE) ? i_data_one : 7'd0;
        o_res.value     = (ev != EV_NONE) ? val : 14'd0;
    end

    assign o_asm = nxt;

endmodule

>>> hw/rtl/midi_channel_decoder_rpn_core.sv
// top level: midi channel decoder with rpn/nrpn assembly and held-note tracking
// flow: an accepted input transaction waits in the input register until the result
//   register is free, then is decoded into the result register and is on the output
// throughput: one transaction per cycle while the output is not stalled, set by the
//   single decode pass between the input register and the result register
// reset: synchronous active-low; clears valids, assembler, held-note bitmap, count
//   and batch tracking; no clearing pass is needed
module midi_channel_decoder_rpn_core
    import mcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_status,
    input  logic [6:0]  i_data_one,
    input  logic [6:0]  i_data_two,
    input  logic        i_batch_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_res,
    output logic [6:0]  o_index,
    output logic [13:0] o_value,
    output logic        o_param_done,
    output logic        o_param_is_nrpn,
    output logic [13:0] o_param_number,
    output logic [13:0] o_param_value,
    output logic        o_active_changed,
    output logic        o_active_level
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_status;
    logic [6:0]  r_data_one;
    logic [6:0]  r_data_two;
    logic        r_batch_end;

    // decode state
    t_asm_state           r_asm;
    t_asm_state           n_asm;
    logic [NUM_NOTES-1:0] r_note_held;
    logic [COUNT_W-1:0]   r_held_count;
    logic [COUNT_W-1:0]   n_held_count;
    logic                 r_batch_start_active;
    logic                 r_in_batch;

    // result register
    logic        r_out_valid;
    t_decode_res r_res;
    logic        r_active_changed;
    logic        r_active_level;

    t_decode_res dec_res;
    t_note_op    note_op;
    logic        out_free;
    logic        advance;
    logic        start_active;
    logic        now_active;
    logic        active_changed;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    mcd_decode u_decode (
        .i_status   (r_status),
        .i_data_one (r_data_one),
        .i_data_two (r_data_two),
        .i_held     (r_note_held[r_data_one]),
        .i_asm      (r_asm),
        .o_asm      (n_asm),
        .o_res      (dec_res),
        .o_note     (note_op)
    );

    // held count and batch comparison
    always_comb begin
        n_held_count = r_held_count;
        if (note_op.note_set) begin
            n_held_count = r_held_count + COUNT_W'(1);
        end else if (note_op.note_clr) begin
            n_held_count = r_held_count - COUNT_W'(1);
        end
        start_active   = r_in_batch ? r_batch_start_active : (r_held_count != '0);
        now_active     = (n_held_count != '0);
        active_changed = r_batch_end && (now_active != start_active);
    end

    // input register transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_status    <= i_status;
            r_data_one  <= i_data_one;
            r_data_two  <= i_data_two;
            r_batch_end <= i_batch_end;
        end
    end

    // state update on each decoded transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asm                <= '{mode: MODE_IDLE, step: STEP_IDLE, default: '0};
            r_note_held          <= '0;
            r_held_count         <= '0;
            r_batch_start_active <= 1'b0;
            r_in_batch           <= 1'b0;
        end else if (advance) begin
            r_asm                <= n_asm;
            r_held_count         <= n_held_count;
            r_batch_start_active <= start_active;
            r_in_batch           <= !r_batch_end;
            if (note_op.note_set) begin
                r_note_held[r_data_one] <= 1'b1;
            end else if (note_op.note_clr) begin
                r_note_held[r_data_one] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (advance) begin
            r_res            <= dec_res;
            r_active_changed <= active_changed;
            r_active_level   <= active_changed && now_active;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_res.event_res;
    assign o_index          = r_res.index;
    assign o_value          = r_res.value;
    assign o_param_done     = r_res.param_done;
    assign o_param_is_nrpn  = r_res.param_is_nrpn;
    assign o_param_number   = r_res.param_number;
    assign o_param_value    = r_res.param_value;
    assign o_active_changed = r_active_changed;
    assign o_active_level   = r_active_level;

    // held count tracks the bitmap population
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held_count) == $countones(r_note_held))
        else $error("held count does not match held-note bitmap");

    // assembler mode and step agree
    a_asm_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_asm.mode == MODE_IDLE) == (r_asm.step == STEP_IDLE))
        else $error("assembler mode and step disagree");

    // level is only reported with a change
    a_level_with_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_active_changed |-> !o_active_level)
        else $error("active level set without active change");

    // a transaction decoded out of the input register is valid on the output next cycle
    a_advance_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("decoded transaction lost");

endmodule
